/* src/rtr_pkg.sv */
// package for the ring target run ratio detector
// holds field widths, register indexes, reset values and the ratio window test
// no dependencies
package rtr_pkg;

    // fixed field widths
    localparam int PIX_W     = 8;
    localparam int OUT_W     = 12;
    localparam int RUN_W     = 13;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // ratio test operand widths
    localparam int OPD_W  = 16;
    localparam int PROD_W = OPD_W + THR_W;

    // run length saturation
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // default image limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // threshold reset value, 0.5 in Q0.8
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_RATIO   = 2'd0,
        CFG_BAND_RATIO   = 2'd1,
        CFG_PAIR_CENTER  = 2'd2,
        CFG_BLACK_CENTER = 2'd3
    } t_cfg_idx;

    // t < x/y < 1/t, with t in Q0.8, by cross multiplication
    function automatic logic in_window(
        input logic [OPD_W-1:0] x,
        input logic [OPD_W-1:0] y,
        input logic [THR_W-1:0] t
    );
        logic [PROD_W-1:0] xs;
        logic [PROD_W-1:0] ys;
        logic [PROD_W-1:0] ty;
        logic [PROD_W-1:0] tx;
        xs = {x, {THR_W{1'b0}}};
        ys = {y, {THR_W{1'b0}}};
        ty = PROD_W'(y) * PROD_W'(t);
        tx = PROD_W'(x) * PROD_W'(t);
        return (xs > ty) && (tx < ys);
    endfunction

endpackage

/* src/rtr_pix_if.sv */
// pixel request channel of the ring target run ratio detector
// depends on rtr_pkg for the pixel width
interface rtr_pix_if
    import rtr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             row_start;
    logic             frame_start;

    modport source (output valid, output pixel, output row_start, output frame_start,
                    input ready);
    modport sink   (input valid, input pixel, input row_start, input frame_start,
                    output ready);
endinterface

/* src/rtr_det_if.sv */
// detection request channel of the ring target run ratio detector
// depends on rtr_pkg for the coordinate width
interface rtr_det_if
    import rtr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] centre_first;
    logic [OUT_W-1:0] centre_last;
    logic [OUT_W-1:0] left_x;
    logic [OUT_W-1:0] right_x;

    modport source (output valid, output row, output centre_first, output centre_last,
                    output left_x, output right_x, input ready);
    modport sink   (input valid, input row, input centre_first, input centre_last,
                    input left_x, input right_x, output ready);
endinterface

/* src/ring_target_run_ratio_detector.sv */
// Ring target run ratio detector: takes one binarised pixel request per clock when
// not stalled and reports black-white-black-white-black ring patterns along each
// row whose five run lengths fall inside the programmed Q0.8 ratio windows. A
// pixel is taken in every cycle in which the detection register is empty or being
// emptied. The runs as the right black run closes go to a snapshot register; the
// ratio tests sit between it and the detection register. The recurrence is the run
// counter and run shift register update. The user must write thresholds through
// the plain write port only while no pixel is in flight; nothing enforces it.
// depends on rtr_pkg, rtr_pix_if and rtr_det_if
module ring_target_run_ratio_detector
    import rtr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rtr_pix_if.sink              i_pix,
    rtr_det_if.source            o_det,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int RXW = (RW > OUT_W) ? RW : OUT_W;
    localparam int PW  = (CW > OPD_W) ? CW : OPD_W;
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

    // threshold registers
    logic [THR_W-1:0] r_thr_pair;
    logic [THR_W-1:0] r_thr_band;
    logic [THR_W-1:0] r_thr_pc;
    logic [THR_W-1:0] r_thr_bc;

    // run tracking state
    logic [RUN_W-1:0] r_runs [5];
    logic [RUN_W-1:0] r_cur_run;
    logic [PIX_W-1:0] r_cur_val;
    logic [CW-1:0]    r_column;
    logic [RW-1:0]    r_row;

    // snapshot stage
    logic             r_s_valid;
    logic [RUN_W-1:0] r_s_lb;
    logic [RUN_W-1:0] r_s_lw;
    logic [RUN_W-1:0] r_s_c;
    logic [RUN_W-1:0] r_s_rw;
    logic [RUN_W-1:0] r_s_rb;
    logic [CW-1:0]    r_s_w;
    logic [RW-1:0]    r_s_row;

    // detection register
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_row;
    logic [OUT_W-1:0] r_o_cs;
    logic [OUT_W-1:0] r_o_ce;
    logic [OUT_W-1:0] r_o_lx;
    logic [OUT_W-1:0] r_o_rx;

    logic             advance;
    logic             accept;
    logic             new_line;
    logic             closing;
    logic             candidate;

    // pipeline moves whenever the detection register can take a new value
    assign advance     = !r_o_valid || o_det.ready;
    assign i_pix.ready = advance;
    assign accept      = i_pix.valid && advance;
    assign new_line    = i_pix.row_start || i_pix.frame_start;
    assign closing     = !new_line && (i_pix.pixel != r_cur_val);
    assign candidate   = closing && (r_cur_val == '0);

    // threshold writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_pair <= THR_RESET;
            r_thr_band <= THR_RESET;
            r_thr_pc   <= THR_RESET;
            r_thr_bc   <= THR_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAIR_RATIO:   r_thr_pair <= i_cfg_data;
                CFG_BAND_RATIO:   r_thr_band <= i_cfg_data;
                CFG_PAIR_CENTER:  r_thr_pc   <= i_cfg_data;
                CFG_BLACK_CENTER: r_thr_bc   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // run length, column and row update per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_runs[i] <= '0;
            r_cur_run <= '0;
            r_cur_val <= '0;
            r_column  <= '0;
            r_row     <= '0;
        end else if (accept) begin
            if (new_line) begin
                for (int i = 0; i < 5; i++) r_runs[i] <= '0;
                r_cur_val <= i_pix.pixel;
                r_cur_run <= RUN_W'(1);
                r_column  <= CW'(1);
                if (i_pix.frame_start) begin
                    r_row <= '0;
                end else if (r_row < ROW_LAST) begin
                    r_row <= r_row + RW'(1);
                end
            end else begin
                if (closing) begin
                    for (int i = 0; i < 4; i++) r_runs[i] <= r_runs[i+1];
                    r_runs[4] <= r_cur_run;
                    r_cur_val <= i_pix.pixel;
                    r_cur_run <= RUN_W'(1);
                end else if (r_cur_run < RUN_MAX) begin
                    r_cur_run <= r_cur_run + RUN_W'(1);
                end
                if (r_column < COL_LAST) begin
                    r_column <= r_column + CW'(1);
                end
            end
        end
    end

    // snapshot of the five runs when a black run closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (advance) begin
            r_s_valid <= accept && candidate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s_lb  <= r_runs[1];
            r_s_lw  <= r_runs[2];
            r_s_c   <= r_runs[3];
            r_s_rw  <= r_runs[4];
            r_s_rb  <= r_cur_run;
            r_s_w   <= r_column;
            r_s_row <= r_row;
        end
    end

    // ratio window tests
    logic [OPD_W-1:0] lb, lw, c, rw, rb, lp, rp;
    logic             nonzero;
    logic             pattern_ok;

    always_comb begin
        lb = OPD_W'(r_s_lb);
        lw = OPD_W'(r_s_lw);
        c  = OPD_W'(r_s_c);
        rw = OPD_W'(r_s_rw);
        rb = OPD_W'(r_s_rb);
        lp = lb + lw;
        rp = rb + rw;
        nonzero = (lb != '0) && (lw != '0) && (c != '0) && (rw != '0) && (rb != '0);
        pattern_ok = nonzero
            && in_window(lp, rp, r_thr_pair)
            && in_window(lb, rb, r_thr_pair)
            && in_window(lw, rw, r_thr_pair)
            && in_window(lb, rb, r_thr_band)
            && in_window(lw, rw, r_thr_band)
            && in_window(OPD_W'(lp * 2'd3), OPD_W'({c, 2'b00}), r_thr_pc)
            && in_window(OPD_W'(rp * 2'd3), OPD_W'({c, 2'b00}), r_thr_pc)
            && in_window(OPD_W'(lb * 2'd3), c, r_thr_bc)
            && in_window(OPD_W'(rb * 2'd3), c, r_thr_bc);
    end

    // pattern coordinates, clamped at column zero
    logic [PW-1:0]  w, rr, cs_off, ce_off, lx_off, cs, ce, lx;
    logic [RXW-1:0] row_x;

    always_comb begin
        w      = PW'(r_s_w);
        rr     = PW'(r_s_rb) + PW'(r_s_rw);
        cs_off = rr + PW'(r_s_c);
        ce_off = rr + PW'(1);
        lx_off = cs_off + PW'(r_s_lw) + PW'(r_s_lb);
        cs     = (w > cs_off) ? (w - cs_off) : '0;
        ce     = (w > ce_off) ? (w - ce_off) : '0;
        lx     = (w > lx_off) ? (w - lx_off) : '0;
        row_x  = RXW'(r_s_row);
    end

    // detection register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_s_valid && pattern_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_row <= row_x[OUT_W-1:0];
            r_o_cs  <= cs[OUT_W-1:0];
            r_o_ce  <= ce[OUT_W-1:0];
            r_o_lx  <= lx[OUT_W-1:0];
            r_o_rx  <= w[OUT_W-1:0];
        end
    end

    assign o_det.valid        = r_o_valid;
    assign o_det.row          = r_o_row;
    assign o_det.centre_first = r_o_cs;
    assign o_det.centre_last  = r_o_ce;
    assign o_det.left_x       = r_o_lx;
    assign o_det.right_x      = r_o_rx;

`ifndef SYNTHESIS
    // pixels are held back only by a stalled detection
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_det.valid && !o_det.ready))
        else $error("pixel channel stalled without a waiting detection");

    // an accepted pixel always leaves a run of at least one
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (r_cur_run != '0))
        else $error("current run empty after an accepted pixel");

    // column saturates at the last column
    a_column_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= COL_LAST)
        else $error("column beyond the image width");
`endif

endmodule
